// ===== design/api_frame_deframer_defines.svh =====
// Assertion macros for the api_frame_deframer design.
`ifndef API_FRAME_DEFRAMER_DEFINES_SVH
`define API_FRAME_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define AFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AFD_ASSERT_IMP(lbl, ante, cons, msg)
`define AFD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/afd_pkg.sv =====
// Shared types and constants for the frame deframer.
package afd_pkg;

    localparam logic [7:0]  START_BYTE    = 8'h7E;
    localparam logic [7:0]  CSUM_BASE     = 8'hFF;
    localparam logic [16:0] LEN_OVERHEAD  = 17'd4;
    localparam logic [7:0]  DROP_TYPE_RST = 8'h8B;
    localparam logic        DROP_EN_RST   = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_DROP_TYPE = 1'b0;
    localparam logic REG_DROP_EN   = 1'b1;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_FRAME,
        ST_EMIT
    } afd_state_t;

    typedef struct packed {
        logic start;       // open a frame
        logic collect;     // take one in-frame byte
        logic emit_start;  // prime the read-out counter
        logic load;        // read one stored byte into the output register
    } afd_cmd_t;

    typedef struct packed {
        logic is_start;    // current byte is the start byte
        logic is_final;    // current in-frame byte is the checksum byte
        logic pass;        // frame good, fits and not filtered
        logic rd_last;     // read-out counter at the frame's last byte
        logic out_free;    // output register can take a byte
    } afd_stat_t;

endpackage

// ===== design/afd_ctrl.sv =====
// Controller state machine: hunt, collect, emit.
module afd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  afd_pkg::afd_stat_t stat,
    output afd_pkg::afd_cmd_t  cmd
);

    afd_pkg::afd_state_t state_reg;
    afd_pkg::afd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= afd_pkg::ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b1;
        case (state_reg)
            afd_pkg::ST_HUNT:
            begin
                if (in_valid && stat.is_start)
                begin
                    cmd.start  = 1'b1;
                    state_next = afd_pkg::ST_FRAME;
                end
            end
            afd_pkg::ST_FRAME:
            begin
                if (in_valid)
                begin
                    cmd.collect = 1'b1;
                    if (stat.is_final)
                    begin
                        if (stat.pass)
                        begin
                            cmd.emit_start = 1'b1;
                            state_next     = afd_pkg::ST_EMIT;
                        end
                        else
                        begin
                            state_next = afd_pkg::ST_HUNT;
                        end
                    end
                end
            end
            afd_pkg::ST_EMIT:
            begin
                in_ready = 1'b0;
                if (stat.out_free)
                begin
                    cmd.load = 1'b1;
                    if (stat.rd_last)
                    begin
                        state_next = afd_pkg::ST_HUNT;
                    end
                end
            end
            default:
            begin
                state_next = afd_pkg::ST_HUNT;
            end
        endcase
    end

endmodule

// ===== design/afd_datapath.sv =====
// Datapath: counters, checksum, frame store and output register.
`include "api_frame_deframer_defines.svh"

module afd_datapath #(
    parameter int MAX_FRAME = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  logic [7:0]         drop_type,
    input  logic               drop_enable,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [7:0]         frame_byte,
    output logic [5:0]         byte_index,
    output logic               last_byte,
    input  afd_pkg::afd_cmd_t  cmd,
    output afd_pkg::afd_stat_t stat
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam logic [16:0] MAX_LEN = 17'(MAX_FRAME);

    logic [7:0]    store_mem [MAX_FRAME];

    logic [16:0]   count_reg;
    logic [16:0]   count_next;
    logic [16:0]   len_reg;
    logic [7:0]    sum_reg;
    logic [7:0]    hdr_reg;
    logic [7:0]    type_reg;
    logic [CW-1:0] rd_cnt_reg;
    logic [CW-1:0] emit_len_reg;
    logic          out_valid_reg;
    logic [7:0]    frame_byte_reg;
    logic [5:0]    byte_index_reg;
    logic          last_byte_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    type_sel;
    logic          good;
    logic          fits;
    logic          dropped;

    assign count_next = count_reg + 17'd1;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = afd_pkg::START_BYTE;
        if (cmd.start)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.collect && (count_next < MAX_LEN))
        begin
            wr_en   = 1'b1;
            wr_addr = count_next[AW-1:0];
            wr_data = rx_byte;
        end
    end

    // zero-length frame: the type byte is the checksum byte itself
    assign type_sel = (count_next == 17'd3) ? rx_byte : type_reg;
    assign good     = (afd_pkg::CSUM_BASE - sum_reg) == rx_byte;
    assign fits     = len_reg <= MAX_LEN;
    assign dropped  = drop_enable && (type_sel == drop_type);

    assign stat.is_start = rx_byte == afd_pkg::START_BYTE;
    assign stat.is_final = (count_next >= 17'd3) && (count_next == len_reg - 17'd1);
    assign stat.pass     = good && fits && !dropped;
    assign stat.rd_last  = rd_cnt_reg == emit_len_reg - CW'(1);
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.load)
        begin
            frame_byte_reg <= store_mem[rd_cnt_reg[AW-1:0]];
            byte_index_reg <= 6'(rd_cnt_reg);
            last_byte_reg  <= stat.rd_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            hdr_reg       <= '0;
            type_reg      <= '0;
            rd_cnt_reg    <= '0;
            emit_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else if (cmd.collect)
            begin
                count_reg <= count_next;
                if (count_next == 17'd1)
                begin
                    hdr_reg <= rx_byte;
                end
                if (count_next == 17'd2)
                begin
                    len_reg <= {1'b0, hdr_reg, rx_byte} + afd_pkg::LEN_OVERHEAD;
                end
                if (count_next == 17'd3)
                begin
                    type_reg <= rx_byte;
                end
                if ((count_next >= 17'd3) && !stat.is_final)
                begin
                    sum_reg <= sum_reg + rx_byte;
                end
            end
            if (cmd.emit_start)
            begin
                rd_cnt_reg   <= '0;
                emit_len_reg <= len_reg[CW-1:0];
            end
            else if (cmd.load)
            begin
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign byte_index = byte_index_reg;
    assign last_byte  = last_byte_reg;

    `AFD_ASSERT_IMP(a_emit_len_ok, cmd.emit_start, (len_reg <= MAX_LEN) && (len_reg >= 17'd4), "emitted frame length out of range")
    `AFD_ASSERT_IMP(a_no_write_in_emit, cmd.load, !wr_en, "frame store written during read-out")
    `AFD_ASSERT_NXT(a_last_flag, cmd.load && stat.rd_last, last_byte_reg && out_valid_reg, "final read-out byte not flagged last")

endmodule

// ===== design/api_frame_deframer.sv =====
// Top level of the start/length/checksum frame deframer with APB register port.
// Input: one rx byte per cycle while collecting.
// A passing frame of N bytes is read out one byte per cycle unless out_ready stalls;
// after the checksum byte the controller enters read-out, then loads the first byte.
// No input request is taken during read-out: the controller holds in_ready low there.
// Reset: hunting for the start byte, drop_type 0x8B, drop_enable 1, output empty;
// the frame store is not cleared (every byte read is written in the same frame).
module api_frame_deframer #(
    parameter int MAX_FRAME = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // frame byte output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic [5:0]  byte_index,
    output logic        last_byte,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] drop_type_reg;
    logic       drop_en_reg;
    logic       cfg_wr;

    afd_pkg::afd_cmd_t  cmd;
    afd_pkg::afd_stat_t stat;

    // Registers: word 0 drop_type, word 1 drop_enable. Decoded on paddr[2]
    // only; byte offsets within a word are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_type_reg <= afd_pkg::DROP_TYPE_RST;
            drop_en_reg   <= afd_pkg::DROP_EN_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                afd_pkg::REG_DROP_TYPE: drop_type_reg <= pwdata[7:0];
                afd_pkg::REG_DROP_EN:   drop_en_reg   <= pwdata[0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            afd_pkg::REG_DROP_TYPE: prdata = {24'd0, drop_type_reg};
            afd_pkg::REG_DROP_EN:   prdata = {31'd0, drop_en_reg};
            default:                prdata = '0;
        endcase
    end

    // Controller steers hunt / collect / read-out; the datapath holds the
    // counters, running sum, frame store and the output register.
    afd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    afd_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .drop_type   (drop_type_reg),
        .drop_enable (drop_en_reg),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .frame_byte  (frame_byte),
        .byte_index  (byte_index),
        .last_byte   (last_byte),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
